/* rtl/alp_pkg.sv */
// alp_pkg: shared types, codes and sizes for the address lease pool allocator
// used by the request and config interfaces, controller, datapath and top level
package alp_pkg;

  localparam int POOL_SIZE = 128;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int SPAN_W    = $clog2(POOL_SIZE + 1);
  localparam int SUM_W     = ((SPAN_W > 8) ? SPAN_W : 8) + 1;

  localparam int MAC_W     = 48;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_DISCOVER = 2'd1;
  localparam logic [1:0] REQ_REQUEST  = 2'd2;
  localparam logic [1:0] REQ_OTHER    = 2'd3;

  localparam logic [1:0] REPLY_OFFER  = 2'd0;
  localparam logic [1:0] REPLY_ACK    = 2'd1;
  localparam logic [1:0] REPLY_NAK    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEASE_TICKS = 2'd2;

  localparam logic [7:0]  RST_POOL_FIRST  = 8'd50;
  localparam logic [7:0]  RST_POOL_COUNT  = 8'd100;
  localparam logic [15:0] RST_LEASE_TICKS = 16'(60 * 60);

  typedef struct packed {
    logic capture;
    logic res_nak;
    logic res_offer;
    logic grant;
    logic scan_start;
    logic scan_step;
    logic post;
  } alp_cmd_t;

  typedef struct packed {
    logic [1:0] item_type;
    logic       slot_free;
    logic       scan_done;
    logic       out_free;
  } alp_sts_t;

endpackage

/* rtl/alp_req_if.sv */
// alp_req_if: request channel of the lease pool allocator
// depends on alp_pkg
interface alp_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [alp_pkg::MAC_W-1:0] client_mac;
  logic [7:0]                requested_host;

  modport source (output valid, req_type, client_mac, requested_host, input ready);
  modport sink (input valid, req_type, client_mac, requested_host, output ready);
endinterface

/* rtl/alp_rep_if.sv */
// alp_rep_if: reply channel of the lease pool allocator
// depends on no package; its widths are fixed
interface alp_rep_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_kind;
  logic [7:0] assigned_host;

  modport source (output valid, reply_kind, assigned_host, input ready);
  modport sink (input valid, reply_kind, assigned_host, output ready);
endinterface

/* rtl/alp_cfg_if.sv */
// alp_cfg_if: register write channel of the lease pool allocator
// depends on alp_pkg
interface alp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [alp_pkg::CFG_IDX_W-1:0] index;
  logic [alp_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/alp_ctrl.sv */
// alp_ctrl: sequencing state machine of the lease pool allocator
// depends on alp_pkg; drives alp_dpath through alp_cmd_t
module alp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_type,
  output logic              in_ready,
  input  alp_pkg::alp_sts_t sts,
  output alp_pkg::alp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_POST  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_type) inside
            alp_pkg::REQ_TICK: state_next = ST_IDLE;
            alp_pkg::REQ_DISCOVER, alp_pkg::REQ_REQUEST: state_next = ST_LOOK;
            default: begin
              cmd.res_nak = 1'b1;
              state_next  = ST_POST;
            end
          endcase
        end
      end
      ST_LOOK: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.slot_free) begin
          if (sts.item_type == alp_pkg::REQ_DISCOVER) begin
            cmd.res_offer = 1'b1;
          end else begin
            cmd.grant = 1'b1;
          end
          state_next = ST_POST;
        end else if (sts.item_type == alp_pkg::REQ_DISCOVER) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          cmd.res_nak = 1'b1;
          state_next  = ST_POST;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_POST;
        end
      end
      ST_POST: begin
        if (sts.out_free) begin
          cmd.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/alp_dpath.sv */
// alp_dpath: lease table, time counter, config registers, scan pipeline and reply register
// depends on alp_pkg; commanded by alp_ctrl
module alp_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  alp_pkg::alp_cmd_t             cmd,
  output alp_pkg::alp_sts_t             sts,
  input  logic [1:0]                    in_type,
  input  logic [alp_pkg::MAC_W-1:0]     in_mac,
  input  logic [7:0]                    in_host,
  input  logic                          cfg_we,
  input  logic [alp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [alp_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_host
);

  localparam int IW  = alp_pkg::IDX_W;
  localparam int SW  = alp_pkg::SPAN_W;
  localparam int HW  = alp_pkg::SUM_W;
  localparam int MW  = alp_pkg::MAC_W;
  localparam int TW  = alp_pkg::TIME_W;
  localparam int EW  = MW + TW;

  logic [7:0]  pool_first;
  logic [7:0]  pool_count;
  logic [15:0] lease_ticks;
  logic [TW-1:0] now_ticks;

  logic [1:0]    item_type;
  logic [MW-1:0] item_mac;
  logic [7:0]    item_host;

  logic [alp_pkg::POOL_SIZE-1:0] lease_valid;
  logic [EW-1:0] lease_mem [alp_pkg::POOL_SIZE];
  logic [EW-1:0] rdata;
  logic [IW-1:0] rd_addr;

  logic [1:0] res_kind;
  logic [7:0] res_host;

  logic [SW-1:0] span;
  logic [8:0]    host_off;
  logic          in_pool;
  logic [IW-1:0] slot;
  logic [MW-1:0] rd_owner;
  logic [TW-1:0] rd_expiry;
  logic [TW-1:0] age;

  logic [SW-1:0] scan_i;
  logic [HW-1:0] scan_h;
  logic          issue_ok;
  logic          p_vld;
  logic [IW-1:0] p_idx;
  logic [7:0]    p_host;
  logic          scan_hit;
  logic          scan_end;

  // pool span and slot of the requested host
  always_comb begin
    if (9'(pool_count) > 9'(alp_pkg::POOL_SIZE)) begin
      span = SW'(alp_pkg::POOL_SIZE);
    end else begin
      span = SW'(pool_count);
    end
    host_off = {1'b0, item_host} - {1'b0, pool_first};
    in_pool  = (item_host != 8'd0) && (item_host >= pool_first) &&
               (HW'(host_off) < HW'(span));
    slot     = host_off[IW-1:0];
  end

  assign rd_owner  = rdata[EW-1:TW];
  assign rd_expiry = rdata[TW-1:0];
  assign age       = now_ticks - rd_expiry;

  // scan issue side
  assign scan_h   = HW'(pool_first) + HW'(scan_i);
  assign issue_ok = (scan_i < span) && (scan_h <= HW'(8'd255));
  assign scan_hit = p_vld && (p_host != 8'd0) && (!lease_valid[p_idx] || !age[TW-1]);
  assign scan_end = !p_vld && !issue_ok;
  assign rd_addr  = cmd.scan_step ? scan_i[IW-1:0] : slot;

  assign sts.item_type = item_type;
  assign sts.slot_free = in_pool && (!lease_valid[slot] || (rd_owner == '0) ||
                                     (rd_owner == item_mac));
  assign sts.scan_done = scan_hit || scan_end;
  assign sts.out_free  = !out_valid || out_ready;

  // config registers and time counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_first  <= alp_pkg::RST_POOL_FIRST;
      pool_count  <= alp_pkg::RST_POOL_COUNT;
      lease_ticks <= alp_pkg::RST_LEASE_TICKS;
      now_ticks   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          alp_pkg::REG_POOL_FIRST:  pool_first  <= cfg_data[7:0];
          alp_pkg::REG_POOL_COUNT:  pool_count  <= cfg_data[7:0];
          alp_pkg::REG_LEASE_TICKS: lease_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture && (in_type == alp_pkg::REQ_TICK)) begin
        now_ticks <= now_ticks + TW'(1);
      end
    end
  end

  // captured request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_type <= in_type;
      item_mac  <= in_mac;
      item_host <= in_host;
    end
  end

  // lease table memory
  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      lease_mem[slot] <= {item_mac, now_ticks + TW'(lease_ticks)};
    end
    rdata <= lease_mem[rd_addr];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      lease_valid <= '0;
    end else if (cmd.grant) begin
      lease_valid[slot] <= 1'b1;
    end else if (cmd.scan_step && scan_hit) begin
      lease_valid[p_idx] <= 1'b0;
    end
  end

  // scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      p_vld <= 1'b0;
    end else if (cmd.scan_step) begin
      p_vld <= issue_ok && !scan_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_i <= '0;
    end else if (cmd.scan_step) begin
      if (issue_ok) begin
        scan_i <= scan_i + SW'(1);
      end
      p_idx  <= scan_i[IW-1:0];
      p_host <= scan_h[7:0];
    end
  end

  // reply being built
  always_ff @(posedge clk) begin
    if (cmd.res_nak) begin
      res_kind <= alp_pkg::REPLY_NAK;
      res_host <= 8'd0;
    end else if (cmd.res_offer) begin
      res_kind <= alp_pkg::REPLY_OFFER;
      res_host <= item_host;
    end else if (cmd.grant) begin
      res_kind <= alp_pkg::REPLY_ACK;
      res_host <= item_host;
    end else if (cmd.scan_step && scan_hit) begin
      res_kind <= alp_pkg::REPLY_OFFER;
      res_host <= p_host;
    end else if (cmd.scan_step && scan_end) begin
      res_kind <= alp_pkg::REPLY_NAK;
      res_host <= 8'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_kind <= res_kind;
      out_host <= res_host;
    end
  end

endmodule

/* rtl/address_lease_pool_allocator.sv */
// address_lease_pool_allocator: top level joining controller and datapath
// depends on alp_pkg, alp_req_if, alp_rep_if, alp_cfg_if, alp_ctrl, alp_dpath
//
// req carries one message per request: tick, discover, request or other.
// rep carries one reply for every message except a tick.
// cfg writes pool_first (0), pool_count (1) and lease_ticks (2); always ready.
// The user must write cfg only while the block is idle; the block does not enforce it.
// A tick only advances the time counter; an other message is answered with a nak.
// Discover and request look up the lease table memory (registered read)
// in the look and check states before the post state. A discover whose requested
// host is taken or outside the pool scans the pool one entry per cycle through the
// memory read port until it finds a free or expired entry or reaches the pool end.
// One message is worked on at a time; req is ready again once the reply
// has been handed to the output register.
// Reset clears the valid bits of all leases at once, the time counter and
// the config registers to their defaults; no clearing pass is needed.
// A stalled rep holds its reply; the next message may be taken meanwhile
// and its reply waits until the output register is free.
module address_lease_pool_allocator (
  input logic   clk,
  input logic   rst,
  alp_req_if.sink   req,
  alp_rep_if.source rep,
  alp_cfg_if.sink   cfg
);

  alp_pkg::alp_cmd_t cmd;
  alp_pkg::alp_sts_t sts;

  assign cfg.ready = 1'b1;

  alp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_type  (req.req_type),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  alp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_type   (req.req_type),
    .in_mac    (req.client_mac),
    .in_host   (req.requested_host),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (rep.valid),
    .out_ready (rep.ready),
    .out_kind  (rep.reply_kind),
    .out_host  (rep.assigned_host)
  );

endmodule

/* sim/tb_address_lease_pool_allocator.sv */
// tb_address_lease_pool_allocator: self-checking testbench for the lease pool allocator,
// a directed script then random phases, each reply checked against the script or a lease table predictor
// depends on alp_pkg, alp_req_if, alp_rep_if, alp_cfg_if and address_lease_pool_allocator
module tb_address_lease_pool_allocator;

  localparam int RAND_ITEMS  = 820;
  localparam int QUIET_LIMIT = 3000;
  localparam int CFG_SETTLE  = 8;
  localparam int END_SETTLE  = 150;

  localparam logic [alp_pkg::MAC_W-1:0] MAC_A    = 48'h0200_1122_3344;
  localparam logic [alp_pkg::MAC_W-1:0] MAC_B    = 48'h0200_5566_7788;
  localparam logic [alp_pkg::MAC_W-1:0] MAC_C    = 48'h0a00_99aa_bbcc;
  localparam logic [alp_pkg::MAC_W-1:0] MAC_ONES = 48'hffff_ffff_ffff;
  localparam logic [alp_pkg::MAC_W-1:0] MAC_ZERO = 48'h0;

  typedef enum logic {ROW_MSG, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [1:0]                 code;
    logic [alp_pkg::MAC_W-1:0]  mac;
    logic [15:0]                arg;
    logic                       fixed;
    logic [1:0]                 want_kind;
    logic [7:0]                 want_host;
  } script_row_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] host;
  } reply_t;

  localparam int SCRIPT_LEN = 34;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_MSG, alp_pkg::REQ_DISCOVER, MAC_A,    16'd50,  1'b1, alp_pkg::REPLY_OFFER, 8'd50},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_A,    16'd50,  1'b1, alp_pkg::REPLY_ACK,   8'd50},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_B,    16'd50,  1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_DISCOVER, MAC_B,    16'd50,  1'b1, alp_pkg::REPLY_OFFER, 8'd51},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_A,    16'd50,  1'b1, alp_pkg::REPLY_ACK,   8'd50},
    '{ROW_MSG, alp_pkg::REQ_OTHER,    MAC_B,    16'd60,  1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_C,    16'd0,   1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_ONES, 16'd149, 1'b1, alp_pkg::REPLY_ACK,   8'd149},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_C,    16'd150, 1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_C,    16'd49,  1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_C,    16'd255, 1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_ZERO, 16'd60,  1'b1, alp_pkg::REPLY_ACK,   8'd60},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_B,    16'd60,  1'b1, alp_pkg::REPLY_ACK,   8'd60},
    '{ROW_MSG, alp_pkg::REQ_DISCOVER, MAC_C,    16'd149, 1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_TICK,     MAC_ONES, 16'd255, 1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_REG, alp_pkg::REG_POOL_FIRST,  MAC_ZERO, 16'd250, 1'b0, alp_pkg::REPLY_NAK, 8'd0},
    '{ROW_REG, alp_pkg::REG_POOL_COUNT,  MAC_ZERO, 16'd4,   1'b0, alp_pkg::REPLY_NAK, 8'd0},
    '{ROW_REG, alp_pkg::REG_LEASE_TICKS, MAC_ZERO, 16'd1,   1'b0, alp_pkg::REPLY_NAK, 8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_B,    16'd251, 1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_B,    16'd252, 1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_B,    16'd253, 1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_DISCOVER, MAC_C,    16'd250, 1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_TICK,     MAC_ZERO, 16'd0,   1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_DISCOVER, MAC_C,    16'd250, 1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_REG, alp_pkg::REG_POOL_COUNT,  MAC_ZERO, 16'd0,   1'b0, alp_pkg::REPLY_NAK, 8'd0},
    '{ROW_MSG, alp_pkg::REQ_DISCOVER, MAC_A,    16'd0,   1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_A,    16'd250, 1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_REG, alp_pkg::REG_POOL_FIRST,  MAC_ZERO, 16'd1,     1'b0, alp_pkg::REPLY_NAK, 8'd0},
    '{ROW_REG, alp_pkg::REG_POOL_COUNT,  MAC_ZERO, 16'd128,   1'b0, alp_pkg::REPLY_NAK, 8'd0},
    '{ROW_REG, alp_pkg::REG_LEASE_TICKS, MAC_ZERO, 16'd65535, 1'b0, alp_pkg::REPLY_NAK, 8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_A,    16'd1,   1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_C,    16'd128, 1'b0, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_REQUEST,  MAC_C,    16'd129, 1'b1, alp_pkg::REPLY_NAK,   8'd0},
    '{ROW_MSG, alp_pkg::REQ_DISCOVER, MAC_ONES, 16'd129, 1'b0, alp_pkg::REPLY_NAK,   8'd0}
  };

  logic clk;
  logic rst;

  alp_req_if req ();
  alp_rep_if rep ();
  alp_cfg_if cfg ();

  address_lease_pool_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rep (rep),
    .cfg (cfg)
  );

  // lease table mirror
  bit                         lease_held [alp_pkg::POOL_SIZE];
  logic [alp_pkg::MAC_W-1:0]  lease_mac  [alp_pkg::POOL_SIZE];
  logic [alp_pkg::TIME_W-1:0] lease_end  [alp_pkg::POOL_SIZE];
  logic [alp_pkg::TIME_W-1:0] now_ticks;
  logic [7:0]                 cur_first;
  logic [7:0]                 cur_count;
  logic [15:0]                cur_ticks;

  reply_t pending_replies [$];
  int     bad_replies;
  int     quiet_cycles;
  bit     idle_on;
  int     idle_pct;
  int     stall_left;

  logic [1:0] last_kind;
  logic [7:0] last_given;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit free_for(int slot, logic [alp_pkg::MAC_W-1:0] mac);
    return !lease_held[slot] || lease_mac[slot] == '0 || lease_mac[slot] == mac;
  endfunction

  function automatic bit serve_message(input logic [1:0] mtype,
                                       input logic [alp_pkg::MAC_W-1:0] mac,
                                       input logic [7:0] host, output logic [1:0] kind,
                                       output logic [7:0] given);
    int span;
    int slot;
    int h;
    logic [alp_pkg::TIME_W-1:0] age;
    span = (int'(cur_count) < alp_pkg::POOL_SIZE) ? int'(cur_count) : alp_pkg::POOL_SIZE;
    slot = -1;
    kind = alp_pkg::REPLY_NAK;
    given = 8'd0;
    if (host != 8'd0 && host >= cur_first && (int'(host) - int'(cur_first)) < span)
      slot = int'(host) - int'(cur_first);
    if (mtype == alp_pkg::REQ_TICK) begin
      now_ticks = now_ticks + 1;
      return 1'b0;
    end
    if (mtype == alp_pkg::REQ_DISCOVER) begin
      if (slot >= 0 && free_for(slot, mac)) begin
        kind = alp_pkg::REPLY_OFFER;
        given = host;
      end else begin
        for (int i = 0; i < span; i++) begin
          h = int'(cur_first) + i;
          if (h > 255) break;
          if (h == 0) continue;
          age = now_ticks - lease_end[i];
          if (!lease_held[i] || !age[alp_pkg::TIME_W-1]) begin
            // an expired lease is dropped before it is offered
            lease_held[i] = 1'b0;
            lease_mac[i] = '0;
            lease_end[i] = '0;
            kind = alp_pkg::REPLY_OFFER;
            given = 8'(h);
            break;
          end
        end
      end
    end else if (mtype == alp_pkg::REQ_REQUEST) begin
      if (slot >= 0 && free_for(slot, mac)) begin
        lease_held[slot] = 1'b1;
        lease_mac[slot] = mac;
        lease_end[slot] = now_ticks + alp_pkg::TIME_W'(cur_ticks);
        kind = alp_pkg::REPLY_ACK;
        given = host;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_message(input logic [1:0] mtype, input logic [alp_pkg::MAC_W-1:0] mac,
                              input logic [7:0] host, input bit fixed,
                              input logic [1:0] want_kind, input logic [7:0] want_host);
    reply_t r;
    bit has_reply;
    logic [1:0] k;
    logic [7:0] g;
    req.valid <= 1'b1;
    req.req_type <= mtype;
    req.client_mac <= mac;
    req.requested_host <= host;
    do @(posedge clk); while (!req.ready);
    has_reply = serve_message(mtype, mac, host, k, g);
    if (has_reply) begin
      r.kind = fixed ? want_kind : k;
      r.host = fixed ? want_host : g;
      pending_replies.push_back(r);
    end
    last_kind = has_reply ? k : alp_pkg::REPLY_NAK;
    last_given = g;
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    req.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_for_replies(input int settle);
    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [alp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [alp_pkg::CFG_DAT_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      alp_pkg::REG_POOL_FIRST:  cur_first = data[7:0];
      alp_pkg::REG_POOL_COUNT:  cur_count = data[7:0];
      alp_pkg::REG_LEASE_TICKS: cur_ticks = data;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      rep.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!rst && idle_on && $urandom_range(0, 99) < idle_pct) begin
      rep.ready <= 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      rep.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (!rst && rep.valid && rep.ready) begin
      if (pending_replies.size() == 0) begin
        bad_replies++;
        if (bad_replies <= 10)
          $display("unexpected reply: kind %0d host %0d", rep.reply_kind, rep.assigned_host);
      end else begin
        e = pending_replies.pop_front();
        if (rep.reply_kind !== e.kind || rep.assigned_host !== e.host) begin
          bad_replies++;
          if (bad_replies <= 10)
            $display("reply mismatch: expected kind %0d host %0d, got kind %0d host %0d",
                     e.kind, e.host, rep.reply_kind, rep.assigned_host);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rep.valid && rep.ready) || (cfg.valid && cfg.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[address_lease_pool_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    logic [alp_pkg::MAC_W-1:0] clients [4];
    logic [alp_pkg::MAC_W-1:0] mac;
    logic [alp_pkg::MAC_W-1:0] offer_mac;
    logic [7:0]       host;
    logic [7:0]       offer_host;
    logic [1:0]       mtype;
    logic [7:0]       f;
    logic [7:0]       c;
    logic [15:0]      t;
    bit               have_offer;
    bit               phase_idle;
    int               items_left;
    int               phase_len;
    int               span;
    int               sel;

    clk = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = alp_pkg::REQ_TICK;
    req.client_mac = '0;
    req.requested_host = 8'd0;
    cfg.valid = 1'b0;
    cfg.index = alp_pkg::REG_POOL_FIRST;
    cfg.data = '0;
    rep.ready = 1'b0;
    stall_left = 0;
    idle_on = 1'b0;
    idle_pct = 0;
    bad_replies = 0;
    quiet_cycles = 0;
    have_offer = 1'b0;
    offer_host = 8'd0;
    offer_mac = '0;
    for (int i = 0; i < alp_pkg::POOL_SIZE; i++) begin
      lease_held[i] = 1'b0;
      lease_mac[i] = '0;
      lease_end[i] = '0;
    end
    now_ticks = '0;
    cur_first = alp_pkg::RST_POOL_FIRST;
    cur_count = alp_pkg::RST_POOL_COUNT;
    cur_ticks = alp_pkg::RST_LEASE_TICKS;
    for (int i = 0; i < 4; i++) begin
      clients[i][47:32] = 16'($urandom_range(0, 65535));
      clients[i][31:0] = $urandom;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_REG) begin
        wait_for_replies(CFG_SETTLE);
        write_reg(SCRIPT[i].code, SCRIPT[i].arg);
      end else begin
        send_message(SCRIPT[i].code, SCRIPT[i].mac, SCRIPT[i].arg[7:0], SCRIPT[i].fixed,
                     SCRIPT[i].want_kind, SCRIPT[i].want_host);
      end
    end

    items_left = RAND_ITEMS;
    while (items_left > 0) begin
      wait_for_replies(CFG_SETTLE);
      sel = $urandom_range(0, 9);
      f = (sel == 0) ? 8'd1 : (sel == 1) ? 8'd255 :
          (sel == 2) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(1, 254));
      sel = $urandom_range(0, 19);
      c = (sel == 0) ? 8'd128 : (sel == 1) ? 8'($urandom_range(129, 255)) :
          (sel == 2) ? 8'd0 : (sel == 3) ? 8'd1 :
          (sel < 6) ? 8'($urandom_range(9, 127)) : 8'($urandom_range(2, 8));
      sel = $urandom_range(0, 9);
      t = (sel == 0) ? 16'd65535 : (sel == 1) ? 16'd1 :
          (sel == 2) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 12));
      write_reg(alp_pkg::REG_POOL_FIRST, {8'h00, f});
      write_reg(alp_pkg::REG_POOL_COUNT, {8'h00, c});
      write_reg(alp_pkg::REG_LEASE_TICKS, t);
      have_offer = 1'b0;
      sel = $urandom_range(0, 2);
      idle_pct = (sel == 0) ? 0 : (sel == 1) ? 15 : 40;
      phase_idle = (idle_pct != 0);
      phase_len = $urandom_range(25, 70);
      span = (int'(cur_count) < alp_pkg::POOL_SIZE) ? int'(cur_count) : alp_pkg::POOL_SIZE;

      for (int n = 0; n < phase_len && items_left > 0; n++) begin
        idle_on = phase_idle && items_left > 100;
        sel = $urandom_range(0, 9);
        if (sel == 0) mac = MAC_ZERO;
        else if (sel == 1) mac = MAC_ONES;
        else if (sel == 2) begin
          mac[47:32] = 16'($urandom_range(0, 65535));
          mac[31:0] = $urandom;
        end else mac = clients[$urandom_range(0, 3)];
        sel = $urandom_range(0, 9);
        if (sel == 0) host = 8'd0;
        else if (sel == 1) host = 8'($urandom_range(0, 255));
        else host = cur_first + 8'($urandom_range(0, span + 1));
        sel = $urandom_range(0, 99);
        mtype = (sel < 20) ? alp_pkg::REQ_TICK : (sel < 45) ? alp_pkg::REQ_DISCOVER :
                (sel < 94) ? alp_pkg::REQ_REQUEST : alp_pkg::REQ_OTHER;
        // follow an offer with a request for it, as a client would
        if (mtype == alp_pkg::REQ_REQUEST && have_offer && $urandom_range(0, 2) != 0) begin
          host = offer_host;
          mac = offer_mac;
          have_offer = 1'b0;
        end
        send_message(mtype, mac, host, 1'b0, alp_pkg::REPLY_NAK, 8'd0);
        if (mtype == alp_pkg::REQ_DISCOVER && last_kind == alp_pkg::REPLY_OFFER) begin
          have_offer = 1'b1;
          offer_host = last_given;
          offer_mac = mac;
        end
        items_left--;
        if (idle_on && $urandom_range(0, 99) < idle_pct)
          hold_off($urandom_range(1, 14));
        else if ($urandom_range(0, 99) < 2)
          wait_for_replies(1);
      end
    end

    idle_on = 1'b0;
    wait_for_replies(END_SETTLE);
    if (bad_replies == 0 && pending_replies.size() == 0)
      $display("[address_lease_pool_allocator] OK");
    else
      $display("[address_lease_pool_allocator] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/alp_pkg.sv
rtl/alp_req_if.sv
rtl/alp_rep_if.sv
rtl/alp_cfg_if.sv
rtl/alp_ctrl.sv
rtl/alp_dpath.sv
rtl/address_lease_pool_allocator.sv
sim/tb_address_lease_pool_allocator.sv
